@@ sv/stq_pkg.sv @@
package stq_pkg;

    // input item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SET_OK   = 2'd0;
    localparam logic [1:0] KIND_SET_FULL = 2'd1;
    localparam logic [1:0] KIND_EXPIRED  = 2'd2;
    localparam logic [1:0] KIND_REPORT   = 2'd3;

    // time constants
    localparam logic [63:0] TIME_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TIME_SAT      = 64'hFFFF_FFFF_FFFF_FFFE;

    // most expiries emitted by one tick
    localparam int RESULT_CAP = 32;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    // stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK
    } stq_state_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic remove;
        logic stop_sel;
    } cell_cmd_t;

endpackage

@@ sv/stq_cell.sv @@
module stq_cell #(
    parameter int SLOT_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  stq_pkg::cell_cmd_t cmd,
    input  logic               shift_in,
    input  logic [63:0]        new_target,
    input  logic [SLOT_W-1:0]  new_slot,
    input  logic [7:0]         new_tag,
    input  logic [SLOT_W-1:0]  match_slot,
    input  logic               prev_valid,
    input  logic               prev_le,
    input  logic [63:0]        prev_target,
    input  logic [SLOT_W-1:0]  prev_slot,
    input  logic [7:0]         prev_tag,
    input  logic               next_valid,
    input  logic [63:0]        next_target,
    input  logic [SLOT_W-1:0]  next_slot,
    input  logic [7:0]         next_tag,
    output logic               valid,
    output logic [63:0]        target,
    output logic [SLOT_W-1:0]  slot,
    output logic [7:0]         tag,
    output logic               le,
    output logic               shift_out
);
    import stq_pkg::*;

    logic              valid_reg, valid_next;
    logic [63:0]       target_reg, target_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        tag_reg, tag_next;
    logic              match;
    logic              shift;

    // local compares against the broadcast entry and slot
    assign le    = valid_reg && (target_reg <= new_target);
    assign match = valid_reg && (slot_reg == match_slot);
    assign shift = cmd.remove && (shift_in || (cmd.stop_sel && match));
    assign shift_out = shift;

    // next content: keep, take new, take from the left or from the right
    always_comb
    begin
        valid_next  = valid_reg;
        target_next = target_reg;
        slot_next   = slot_reg;
        tag_next    = tag_reg;
        if (cmd.insert && !le)
        begin
            if (prev_le)
            begin
                valid_next  = 1'b1;
                target_next = new_target;
                slot_next   = new_slot;
                tag_next    = new_tag;
            end
            else
            begin
                valid_next  = prev_valid;
                target_next = prev_target;
                slot_next   = prev_slot;
                tag_next    = prev_tag;
            end
        end
        else if (shift)
        begin
            valid_next  = next_valid;
            target_next = next_target;
            slot_next   = next_slot;
            tag_next    = next_tag;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        slot_reg   <= slot_next;
        tag_reg    <= tag_next;
    end

    assign valid  = valid_reg;
    assign target = target_reg;
    assign slot   = slot_reg;
    assign tag    = tag_reg;

endmodule

@@ sv/stq_slots.sv @@
module stq_slots #(
    parameter int SLOT_COUNT = 32,
    parameter int SLOT_W     = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  set_en,
    input  logic [SLOT_W-1:0]     set_idx,
    input  logic                  clr_en,
    input  logic [SLOT_W-1:0]     clr_idx,
    output logic                  free_found,
    output logic [SLOT_W-1:0]     free_idx,
    output logic [SLOT_COUNT-1:0] busy
);
    import stq_pkg::*;

    logic [SLOT_COUNT-1:0] busy_reg, busy_next;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // claim and release
    always_comb
    begin
        busy_next = busy_reg;
        if (set_en)
        begin
            busy_next[set_idx] = 1'b1;
        end
        if (clr_en)
        begin
            busy_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ sv/sorted_timer_queue_unit.sv @@
// Timer queue on a stream interface. Each slave transfer carries a mode in tuser: a tick
// advances the 64-bit tick count and emits every timer whose expiry time is reached, earliest
// first, the final one with tlast; a set takes the lowest free slot, stores now plus countdown
// (held below all-ones) behind entries of equal time, and returns the slot or a pool-full
// kind; a stop silently frees a slot and drops its entry; a read reports the count. Pending
// timers live in a row of SLOT_COUNT cells kept sorted by expiry time; an insert or removal
// shifts every cell of the row together. Set, stop and read are accepted in the idle state and
// then act on the cell row; a tick is accepted, then pops one expiry per cycle from the head
// of the row while results are taken, at most 32 per tick. A result that waits on the master
// side stalls a set, a read or a tick for as long as it waits.
// After reset the block is ready at once.
module sorted_timer_queue_unit #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // countdown [31:0], handler_tag [39:32], slot_index [44:40], zero [47:45]
    input  logic [stq_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode [1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot_id [4:0], tag_out [12:5], time_value [76:13], zero [79:77]
    output logic [stq_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind [1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import stq_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // input field view
    logic [1:0]  in_mode;
    logic [31:0] in_countdown;
    logic [7:0]  in_tag;
    logic [4:0]  in_sidx;
    logic        in_xfer;

    assign in_mode      = s_tuser;
    assign in_countdown = s_tdata[31:0];
    assign in_tag       = s_tdata[39:32];
    assign in_sidx      = s_tdata[44:40];
    assign in_xfer      = s_tvalid && s_tready;

    // control and item registers
    stq_state_t        state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [63:0]       tgt_reg;
    logic [7:0]        tag_reg;
    logic [SLOT_W-1:0] sidx_reg;
    logic              stop_ok_reg;
    logic [63:0]       now_reg, now_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [4:0]  out_slot_reg, out_slot_next;
    logic [7:0]  out_tag_reg, out_tag_next;
    logic [63:0] out_time_reg;
    logic        out_last_reg, out_last_next;
    logic        out_free;
    logic        emit;

    // cell row wiring
    logic              c_valid  [SLOT_COUNT];
    logic [63:0]       c_target [SLOT_COUNT];
    logic [SLOT_W-1:0] c_slot   [SLOT_COUNT];
    logic [7:0]        c_tag    [SLOT_COUNT];
    logic              c_le     [SLOT_COUNT];
    logic              c_shift  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_vec;
    logic [SLOT_COUNT-1:0] valid_inc;
    cell_cmd_t         cmd;
    logic              chain_in;

    // slot pool
    logic                  slot_set, slot_clr;
    logic [SLOT_W-1:0]     slot_clr_idx;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_COUNT-1:0] busy_vec;

    // expiry time with saturation below all-ones
    logic [64:0] tgt_sum;
    logic [63:0] tgt_calc;

    assign tgt_sum  = {1'b0, now_reg} + {33'd0, in_countdown};
    assign tgt_calc = (tgt_sum[64] || (tgt_sum[63:0] == TIME_ALL_ONES)) ? TIME_SAT
                                                                         : tgt_sum[63:0];

    // head of the row against the current count
    logic head_exp, second_exp;

    assign head_exp   = c_valid[0] && (c_target[0] <= now_reg);
    assign second_exp = c_valid[1] && (c_target[1] <= now_reg);
    assign out_free   = !m_valid_reg || m_tready;

    stq_slots #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_en     (slot_set),
        .set_idx    (free_idx),
        .clr_en     (slot_clr),
        .clr_idx    (slot_clr_idx),
        .free_found (free_found),
        .free_idx   (free_idx),
        .busy       (busy_vec)
    );

    // sorted row of cells
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        logic              p_valid, p_le, n_valid, s_in;
        logic [63:0]       p_target, n_target;
        logic [SLOT_W-1:0] p_slot, n_slot;
        logic [7:0]        p_tag, n_tag;

        if (i == 0)
        begin : g_first
            assign p_valid  = 1'b1;
            assign p_le     = 1'b1;
            assign p_target = tgt_reg;
            assign p_slot   = free_idx;
            assign p_tag    = tag_reg;
            assign s_in     = chain_in;
        end
        else
        begin : g_inner
            assign p_valid  = c_valid[i-1];
            assign p_le     = c_le[i-1];
            assign p_target = c_target[i-1];
            assign p_slot   = c_slot[i-1];
            assign p_tag    = c_tag[i-1];
            assign s_in     = c_shift[i-1];
        end

        if (i == SLOT_COUNT - 1)
        begin : g_last
            assign n_valid  = 1'b0;
            assign n_target = c_target[i];
            assign n_slot   = c_slot[i];
            assign n_tag    = c_tag[i];
        end
        else
        begin : g_body
            assign n_valid  = c_valid[i+1];
            assign n_target = c_target[i+1];
            assign n_slot   = c_slot[i+1];
            assign n_tag    = c_tag[i+1];
        end

        stq_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .shift_in    (s_in),
            .new_target  (tgt_reg),
            .new_slot    (free_idx),
            .new_tag     (tag_reg),
            .match_slot  (sidx_reg),
            .prev_valid  (p_valid),
            .prev_le     (p_le),
            .prev_target (p_target),
            .prev_slot   (p_slot),
            .prev_tag    (p_tag),
            .next_valid  (n_valid),
            .next_target (n_target),
            .next_slot   (n_slot),
            .next_tag    (n_tag),
            .valid       (c_valid[i]),
            .target      (c_target[i]),
            .slot        (c_slot[i]),
            .tag         (c_tag[i]),
            .le          (c_le[i]),
            .shift_out   (c_shift[i])
        );

        assign valid_vec[i] = c_valid[i];
    end

    assign valid_inc = valid_vec + SLOT_COUNT'(1);

    // sequencer: next state, cell commands and result
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        chain_in      = 1'b0;
        slot_set      = 1'b0;
        slot_clr      = 1'b0;
        slot_clr_idx  = sidx_reg;
        emit          = 1'b0;
        out_kind_next = KIND_REPORT;
        out_slot_next = '0;
        out_tag_next  = '0;
        out_last_next = 1'b1;
        now_next      = now_reg;
        cnt_next      = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cnt_next = '0;
                    if (in_mode == MODE_TICK)
                    begin
                        now_next   = now_reg + 64'd1;
                        state_next = ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_SET:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (free_found)
                            begin
                                cmd.insert    = 1'b1;
                                slot_set      = 1'b1;
                                out_kind_next = KIND_SET_OK;
                                out_slot_next = 5'(free_idx);
                            end
                            else
                            begin
                                out_kind_next = KIND_SET_FULL;
                            end
                        end
                    end
                    MODE_STOP:
                    begin
                        state_next = ST_IDLE;
                        if (stop_ok_reg && busy_vec[sidx_reg])
                        begin
                            cmd.remove   = 1'b1;
                            cmd.stop_sel = 1'b1;
                            slot_clr     = 1'b1;
                        end
                    end
                    MODE_READ:
                    begin
                        if (out_free)
                        begin
                            emit          = 1'b1;
                            out_kind_next = KIND_REPORT;
                            state_next    = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_TICK:
            begin
                if (!head_exp)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    // pop the head, the whole row moves left
                    emit          = 1'b1;
                    cmd.remove    = 1'b1;
                    chain_in      = 1'b1;
                    slot_clr      = 1'b1;
                    slot_clr_idx  = c_slot[0];
                    out_kind_next = KIND_EXPIRED;
                    out_slot_next = 5'(c_slot[0]);
                    out_tag_next  = c_tag[0];
                    out_last_next = (cnt_reg == CNT_W'(RESULT_CAP - 1)) || !second_exp;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    if (out_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = emit ? 1'b1 : (m_valid_reg && !m_tready);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg    <= in_mode;
            tgt_reg     <= tgt_calc;
            tag_reg     <= in_tag;
            sidx_reg    <= SLOT_W'(in_sidx);
            stop_ok_reg <= ({27'd0, in_sidx} < 32'(SLOT_COUNT));
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= out_kind_next;
            out_slot_reg <= out_slot_next;
            out_tag_reg  <= out_tag_next;
            out_time_reg <= now_reg;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_time_reg, out_tag_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // pending cells stay packed from the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & valid_inc) == '0)
        else $error("cell row has a gap");

    // as many busy slots as pending cells
    a_pool: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_vec) == $countones(valid_vec))
        else $error("slot pool and cell row disagree");

    // head of the row expires no later than the second cell
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[1] |-> (c_target[0] <= c_target[1]))
        else $error("cell row out of order");

endmodule

@@ test/sorted_timer_queue_unit_test.sv @@
`timescale 1ns / 1ps

module sorted_timer_queue_unit_test;

    import stq_pkg::*;

    localparam int SLOT_TOTAL = 32;

    // one slave transfer: mode plus the data fields
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] countdown;
        logic [7:0]  tag;
        logic [4:0]  slot_index;
    } timer_cmd_t;

    // one master transfer as the queue should report it
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot_id;
        logic [7:0]  tag_out;
        logic [63:0] time_value;
        logic        last;
    } timer_result_t;

    // pending timer, kept in expiry order
    typedef struct {
        logic [63:0] due;
        logic [4:0]  slot;
        logic [7:0]  tag;
    } timer_entry_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = MODE_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // shadow of the timer queue
    logic [63:0]   tick_count = '0;
    bit            slot_taken [SLOT_TOTAL];
    timer_entry_t  timer_order [$];
    timer_result_t expected_results [$];

    timer_cmd_t    pending_cmds [$];
    timer_cmd_t    live_cmd;
    int            send_wait = 0;
    int            take_wait = 0;
    bit            steady_flow = 1'b0;
    bit            run_failed = 1'b0;

    sorted_timer_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // idle cycles before the next transfer on either side
    function automatic int draw_wait();
        if (steady_flow)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // advance the shadow queue by one command and record what it should emit
    task automatic apply_timer_cmd(input timer_cmd_t cmd);
        int            fired;
        int            free_slot;
        int            pos;
        logic [64:0]   sum;
        timer_entry_t  ent;
        timer_result_t res;
        case (cmd.mode)
            MODE_TICK:
            begin
                tick_count = tick_count + 64'd1;
                fired = 0;
                while (fired < RESULT_CAP && timer_order.size() > 0
                       && timer_order[0].due <= tick_count)
                begin
                    slot_taken[timer_order[0].slot] = 1'b0;
                    res = '{KIND_EXPIRED, timer_order[0].slot, timer_order[0].tag,
                            tick_count, 1'b0};
                    expected_results.push_back(res);
                    void'(timer_order.pop_front());
                    fired++;
                end
                if (fired > 0)
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
            MODE_SET:
            begin
                free_slot = -1;
                for (int s = 0; s < SLOT_TOTAL; s++)
                    if (!slot_taken[s] && free_slot < 0)
                        free_slot = s;
                if (free_slot < 0 || timer_order.size() >= SLOT_TOTAL)
                begin
                    res = '{KIND_SET_FULL, 5'd0, 8'd0, tick_count, 1'b1};
                    expected_results.push_back(res);
                end
                else
                begin
                    // expiry held just below the all-ones sentinel
                    sum = {1'b0, tick_count} + {33'd0, cmd.countdown};
                    if (sum[64] || sum[63:0] == TIME_ALL_ONES)
                        ent.due = TIME_SAT;
                    else
                        ent.due = sum[63:0];
                    ent.slot = 5'(free_slot);
                    ent.tag = cmd.tag;
                    // behind every entry with an equal time
                    pos = 0;
                    while (pos < timer_order.size() && timer_order[pos].due <= ent.due)
                        pos++;
                    timer_order.insert(pos, ent);
                    slot_taken[free_slot] = 1'b1;
                    res = '{KIND_SET_OK, 5'(free_slot), 8'd0, tick_count, 1'b1};
                    expected_results.push_back(res);
                end
            end
            MODE_STOP:
            begin
                if (slot_taken[cmd.slot_index])
                begin
                    slot_taken[cmd.slot_index] = 1'b0;
                    for (int i = 0; i < timer_order.size(); i++)
                        if (timer_order[i].slot == cmd.slot_index)
                        begin
                            timer_order.delete(i);
                            break;
                        end
                end
            end
            default:
            begin
                res = '{KIND_REPORT, 5'd0, 8'd0, tick_count, 1'b1};
                expected_results.push_back(res);
            end
        endcase
    endtask

    // slave side: present queued commands, predict on each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= MODE_TICK;
            send_wait = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                apply_timer_cmd(live_cmd);
                send_wait = draw_wait();
            end
            if (send_wait == 0 && pending_cmds.size() > 0)
            begin
                live_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, live_cmd.slot_index, live_cmd.tag, live_cmd.countdown};
                s_tuser <= live_cmd.mode;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (send_wait > 0)
                    send_wait--;
            end
        end
    end

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            run_failed = 1'b1;
        end
    endfunction

    // master side: stall at random, compare each transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_wait = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d time 0x%0h",
                       m_tuser, m_tdata[4:0], m_tdata[76:13]);
                run_failed = 1'b1;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_tuser));
                check_field("slot_id", 64'(want.slot_id), 64'(m_tdata[4:0]));
                check_field("tag_out", 64'(want.tag_out), 64'(m_tdata[12:5]));
                check_field("time_value", want.time_value, m_tdata[76:13]);
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
            take_wait = draw_wait();
            if (take_wait > 0)
                m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            if (take_wait > 0)
                take_wait--;
            else
                m_tready <= 1'b1;
        end
    end

    task automatic queue_cmd(input logic [1:0] mode, input logic [31:0] countdown,
                             input logic [7:0] tag, input logic [4:0] slot_index);
        timer_cmd_t cmd;
        cmd = '{mode, countdown, tag, slot_index};
        pending_cmds.push_back(cmd);
    endtask

    function automatic logic [4:0] pick_busy_slot();
        int busy [$];
        for (int s = 0; s < SLOT_TOTAL; s++)
            if (slot_taken[s])
                busy.push_back(s);
        if (busy.size() == 0)
            return 5'($urandom_range(0, SLOT_TOTAL - 1));
        return 5'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    // clear the pool, fill it with timers due together, overflow it, then tick them out
    task automatic run_pool_flood(inout int count);
        int cd;
        while (pending_cmds.size() > 0 || s_tvalid)
            @(posedge clk);
        for (int s = 0; s < SLOT_TOTAL; s++)
            if (slot_taken[s])
            begin
                queue_cmd(MODE_STOP, $urandom, 8'($urandom), 5'(s));
                count++;
            end
        cd = $urandom_range(0, 6);
        for (int i = 0; i < SLOT_TOTAL; i++)
            queue_cmd(MODE_SET, 32'(cd), 8'($urandom), 5'($urandom));
        repeat ($urandom_range(1, 2))
            queue_cmd(MODE_SET, $urandom, 8'($urandom), 5'($urandom));
        repeat ((cd > 0 ? cd : 1) + 1)
            queue_cmd(MODE_TICK, $urandom, 8'($urandom), 5'($urandom));
        count += SLOT_TOTAL + cd + 4;
    endtask

    // run limit
    initial
    begin
        #20_000_000;
        $display("sorted_timer_queue_unit regression: fail");
        $finish;
    end

    initial
    begin
        int          random_cmds;
        int          pick;
        int          spread;
        bit          flooded;
        logic [4:0]  idx;
        logic [31:0] cd;

        random_cmds = 0;
        flooded = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty tick, sentinel-free extremes, equal times, stops, slot reuse
        queue_cmd(MODE_READ, 32'd0, 8'd0, 5'd0);
        queue_cmd(MODE_TICK, 32'd0, 8'd0, 5'd0);
        queue_cmd(MODE_SET, 32'd0, 8'h00, 5'd0);
        queue_cmd(MODE_SET, 32'hFFFF_FFFF, 8'hFF, 5'h1F);
        queue_cmd(MODE_SET, 32'd3, 8'hA5, 5'd0);
        queue_cmd(MODE_SET, 32'd3, 8'h5A, 5'd0);
        queue_cmd(MODE_SET, 32'd2, 8'h3C, 5'd0);
        queue_cmd(MODE_STOP, 32'd0, 8'd0, 5'd17);
        queue_cmd(MODE_STOP, 32'hFFFF_FFFF, 8'hFF, 5'd1);
        queue_cmd(MODE_TICK, 32'd0, 8'd0, 5'd0);
        queue_cmd(MODE_SET, 32'd1, 8'h81, 5'd31);
        queue_cmd(MODE_TICK, 32'd0, 8'd0, 5'd0);
        queue_cmd(MODE_TICK, 32'd0, 8'd0, 5'd0);
        queue_cmd(MODE_STOP, 32'd0, 8'd0, 5'd2);
        queue_cmd(MODE_STOP, 32'd0, 8'd0, 5'd31);
        queue_cmd(MODE_READ, 32'hFFFF_FFFF, 8'hFF, 5'h1F);
        queue_cmd(MODE_TICK, 32'hFFFF_FFFF, 8'hFF, 5'h1F);
        queue_cmd(MODE_READ, $urandom, 8'($urandom), 5'($urandom));

        // random: mostly short timers that really expire, with floods and noise
        while (random_cmds < 380)
        begin
            if ($urandom_range(0, 39) == 0)
                steady_flow = ($urandom_range(0, 2) == 0);
            // keep the generator close to the shadow state
            while (pending_cmds.size() > 8)
                @(posedge clk);
            if (!flooded || $urandom_range(0, 79) == 0)
            begin
                run_pool_flood(random_cmds);
                flooded = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    queue_cmd(MODE_TICK, $urandom, 8'($urandom), 5'($urandom));
                    random_cmds++;
                end
                else if (pick < 70)
                begin
                    spread = $urandom_range(0, 9);
                    if (spread < 7)
                        cd = $urandom_range(0, 24);
                    else if (spread < 9)
                        cd = $urandom_range(0, 65535);
                    else
                        cd = $urandom;
                    queue_cmd(MODE_SET, cd, 8'($urandom), 5'($urandom));
                    random_cmds++;
                end
                else if (pick < 85)
                begin
                    if ($urandom_range(0, 3) != 0)
                        idx = pick_busy_slot();
                    else
                        idx = 5'($urandom);
                    queue_cmd(MODE_STOP, $urandom, 8'($urandom), idx);
                    random_cmds++;
                end
                else
                begin
                    queue_cmd(MODE_READ, $urandom, 8'($urandom), 5'($urandom));
                    random_cmds++;
                end
            end
        end

        // drain, then allow for a late or spurious transfer
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!run_failed && expected_results.size() == 0)
            $display("sorted_timer_queue_unit regression: pass");
        else
            $display("sorted_timer_queue_unit regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/stq_pkg.sv
sv/stq_cell.sv
sv/stq_slots.sv
sv/sorted_timer_queue_unit.sv
test/sorted_timer_queue_unit_test.sv
